### hw/rtl/tod_pkg.sv
// Shared types and constants of the time-of-day arithmetic unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tod_pkg;

  typedef enum logic [2:0] {
    OpAdd   = 3'd0,
    OpSub   = 3'd1,
    OpInc   = 3'd2,
    OpDec   = 3'd3,
    OpMul   = 3'd4,
    OpDiv   = 3'd5,
    OpRatio = 3'd6,
    OpCmp   = 3'd7
  } op_e;

  // seconds of one day and the widths that follow from it
  localparam int unsigned SecW          = 17;
  localparam int unsigned RemW          = 34;
  localparam int unsigned QuoW          = 17;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned DivStages     = (QuoW + StepsPerStage - 1) / StepsPerStage;

  localparam logic [SecW-1:0] DaySecs = 17'd86400;

  // word sideband that travels beside the divider
  typedef struct packed {
    op_e  op;
    logic dz;
    logic lt;
    logic eq;
    logic gt;
  } side_t;

endpackage

### hw/rtl/time_of_day_alu.sv
// Time-of-day arithmetic unit, top level. Uses tod_pkg, tod_front, tod_div, tod_split.
// Pipeline of 2 front stages, 9 divider stages at up to 2 quotient bits each, 3 split
// stages and an output register.
// Throughput: one word per cycle; the whole pipeline stalls only while the
// output word waits. Reset clears all valid bits; no other state.
`timescale 1ns / 1ps

module time_of_day_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [4:0]  a_hours_i,
  input  logic [5:0]  a_minutes_i,
  input  logic [5:0]  a_seconds_i,
  input  logic [4:0]  b_hours_i,
  input  logic [5:0]  b_minutes_i,
  input  logic [5:0]  b_seconds_i,
  input  logic [15:0] scalar_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  r_hours_o,
  output logic [5:0]  r_minutes_o,
  output logic [5:0]  r_seconds_o,
  output logic [16:0] ratio_o,
  output logic        is_less_o,
  output logic        is_equal_o,
  output logic        is_greater_o,
  output logic        div_zero_o
);
  import tod_pkg::*;

  logic            en;
  logic            f_valid, d_valid;
  logic [RemW-1:0] f_n;
  logic [SecW-1:0] f_d, d_rem;
  logic [QuoW-1:0] d_quo;
  side_t           f_side, d_side;

  // advance every stage unless the output word is held
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  tod_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .opcode_i, .a_hours_i, .a_minutes_i, .a_seconds_i,
    .b_hours_i, .b_minutes_i, .b_seconds_i, .scalar_i,
    .valid_o(f_valid), .n_o(f_n), .d_o(f_d), .side_o(f_side)
  );

  tod_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid), .n_i(f_n), .d_i(f_d),
    .side_i(f_side), .valid_o(d_valid), .rem_o(d_rem), .quo_o(d_quo), .side_o(d_side)
  );

  tod_split u_split (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_valid), .rem_i(d_rem), .quo_i(d_quo),
    .side_i(d_side), .valid_o(out_valid_o), .r_hours_o, .r_minutes_o,
    .r_seconds_o, .ratio_o, .is_less_o, .is_equal_o, .is_greater_o, .div_zero_o
  );

`ifndef SYNTHESIS
  // a zero divisor clears every other field
  a_dz_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_zero_o |-> r_hours_o == '0 && r_minutes_o == '0 &&
    r_seconds_o == '0 && ratio_o == '0)
    else $error("div_zero word carries non-zero fields");

  // compare flags are exclusive
  a_cmp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({is_less_o, is_equal_o, is_greater_o}) <= 1)
    else $error("more than one compare flag set");

  // split time stays within a day
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> r_hours_o <= 5'd23 && r_minutes_o <= 6'd59 && r_seconds_o <= 6'd59)
    else $error("result time out of range");
`endif

endmodule

### hw/rtl/tod_front.sv
// Front stages: fold both times into seconds of the day, then form the
// dividend, divisor and compare flags. Depends on tod_pkg.
`timescale 1ns / 1ps

module tod_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [2:0]                opcode_i,
  input  logic [4:0]                a_hours_i,
  input  logic [5:0]                a_minutes_i,
  input  logic [5:0]                a_seconds_i,
  input  logic [4:0]                b_hours_i,
  input  logic [5:0]                b_minutes_i,
  input  logic [5:0]                b_seconds_i,
  input  logic [15:0]               scalar_i,
  output logic                      valid_o,
  output logic [tod_pkg::RemW-1:0]  n_o,
  output logic [tod_pkg::SecW-1:0]  d_o,
  output tod_pkg::side_t            side_o
);
  import tod_pkg::*;

  logic            v1_q, v2_q;
  logic [SecW-1:0] ta_raw, tb_raw, ta_d, tb_d, ta_q, tb_q;
  logic [15:0]     sc_q;
  op_e             op_q;
  logic [32:0]     prod;
  logic [RemW-1:0] n_d, n_q;
  logic [SecW-1:0] d_d, d_q;
  side_t           side_d, side_q;

  // convert to seconds; raw value stays below two days
  assign ta_raw = SecW'(a_hours_i) * SecW'(3600) + SecW'(a_minutes_i) * SecW'(60)
                + SecW'(a_seconds_i);
  assign tb_raw = SecW'(b_hours_i) * SecW'(3600) + SecW'(b_minutes_i) * SecW'(60)
                + SecW'(b_seconds_i);
  assign ta_d = (ta_raw >= DaySecs) ? ta_raw - DaySecs : ta_raw;
  assign tb_d = (tb_raw >= DaySecs) ? tb_raw - DaySecs : tb_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ta_q   <= ta_d;
      tb_q   <= tb_d;
      sc_q   <= scalar_i;
      op_q   <= op_e'(opcode_i);
      n_q    <= n_d;
      d_q    <= d_d;
      side_q <= side_d;
    end
  end

  // pick dividend and divisor per operation; time results reduce modulo a day
  assign prod = 33'(ta_q) * 33'(sc_q);

  always_comb begin
    n_d = '0;
    d_d = DaySecs;
    case (op_q)
      OpAdd:   n_d = RemW'(ta_q) + RemW'(tb_q);
      OpSub:   n_d = RemW'(ta_q) + RemW'(DaySecs) - RemW'(tb_q);
      OpInc:   n_d = RemW'(ta_q) + RemW'(1);
      OpDec:   n_d = RemW'(ta_q) + RemW'(DaySecs) - RemW'(1);
      OpMul:   n_d = RemW'(prod);
      OpDiv: begin
        n_d = RemW'(ta_q);
        d_d = SecW'(sc_q);
      end
      OpRatio: begin
        n_d = RemW'(ta_q);
        d_d = tb_q;
      end
      default: n_d = '0;
    endcase
    side_d.op = op_q;
    side_d.dz = ((op_q == OpDiv) && (sc_q == '0)) || ((op_q == OpRatio) && (tb_q == '0));
    side_d.lt = ta_q < tb_q;
    side_d.eq = ta_q == tb_q;
    side_d.gt = ta_q > tb_q;
  end

  assign valid_o = v2_q;
  assign n_o     = n_q;
  assign d_o     = d_q;
  assign side_o  = side_q;

endmodule

### hw/rtl/tod_div.sv
// Pipelined restoring divider, StepsPerStage quotient bits per stage, fewer in the last.
// Depends on tod_pkg.
`timescale 1ns / 1ps

module tod_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [tod_pkg::RemW-1:0]  n_i,
  input  logic [tod_pkg::SecW-1:0]  d_i,
  input  tod_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [tod_pkg::SecW-1:0]  rem_o,
  output logic [tod_pkg::QuoW-1:0]  quo_o,
  output tod_pkg::side_t            side_o
);
  import tod_pkg::*;

  logic            v_q    [DivStages];
  logic [RemW-1:0] r_q    [DivStages];
  logic [QuoW-1:0] q_q    [DivStages];
  logic [SecW-1:0] d_q    [DivStages];
  side_t           side_q [DivStages];

  for (genvar g = 0; g < DivStages; g++) begin : g_stage
    logic            v_in;
    logic [RemW-1:0] r_in, r_d, sub;
    logic [QuoW-1:0] q_in, q_d;
    logic [SecW-1:0] d_in;
    side_t           s_in;

    if (g == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = n_i;
      assign q_in = '0;
      assign d_in = d_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[g-1];
      assign r_in = r_q[g-1];
      assign q_in = q_q[g-1];
      assign d_in = d_q[g-1];
      assign s_in = side_q[g-1];
    end

    // subtract the shifted divisor where it fits, high bit first
    always_comb begin
      r_d = r_in;
      q_d = q_in;
      sub = '0;
      for (int k = 0; k < StepsPerStage; k++) begin
        if (g * StepsPerStage + k < QuoW) begin
          sub = RemW'(d_in) << (QuoW - 1 - g * StepsPerStage - k);
          if (r_d >= sub) begin
            r_d = r_d - sub;
            q_d[QuoW-1-g*StepsPerStage-k] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[g]    <= r_d;
        q_q[g]    <= q_d;
        d_q[g]    <= d_in;
        side_q[g] <= s_in;
      end
    end
  end

  assign valid_o = v_q[DivStages-1];
  assign rem_o   = r_q[DivStages-1][SecW-1:0];
  assign quo_o   = q_q[DivStages-1];
  assign side_o  = side_q[DivStages-1];

endmodule

### hw/rtl/tod_split.sv
// Back stages: split seconds of the day into hh:mm:ss by reciprocal
// multiplication, mask fields per operation, hold the output word. Depends on tod_pkg.
`timescale 1ns / 1ps

module tod_split (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [tod_pkg::SecW-1:0]  rem_i,
  input  logic [tod_pkg::QuoW-1:0]  quo_i,
  input  tod_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [4:0]                r_hours_o,
  output logic [5:0]                r_minutes_o,
  output logic [5:0]                r_seconds_o,
  output logic [16:0]               ratio_o,
  output logic                      is_less_o,
  output logic                      is_equal_o,
  output logic                      is_greater_o,
  output logic                      div_zero_o
);
  import tod_pkg::*;

  logic            v1_q, v2_q, v3_q, vo_q;
  logic [SecW-1:0] t_d, t1_q;
  logic [32:0]     hprod;
  logic [4:0]      h1_q, h2_q, h3_q;
  logic [QuoW-1:0] qo1_q, qo2_q, qo3_q;
  side_t           s1_q, s2_q, s3_q;
  logic [11:0]     rs_d, rs2_q, rs3_q;
  logic [23:0]     mprod;
  logic [5:0]      mn3_q;
  logic [5:0]      sec_d;
  logic            tm_ok;
  logic [4:0]      rh_q;
  logic [5:0]      rm_q, rsec_q;
  logic [16:0]     ratio_q;
  logic            lt_q, eq_q, gt_q, dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  // hours: t / 3600 as (t * 37283) >> 27, exact below one day
  assign t_d   = (side_i.op == OpDiv) ? quo_i : rem_i;
  assign hprod = 33'(t_d) * 33'(37283);

  // remainder within the hour, then minutes as (r * 4370) >> 18
  assign rs_d  = 12'(t1_q - SecW'(h1_q) * SecW'(3600));
  assign mprod = 24'(rs2_q) * 24'(4370);
  assign sec_d = 6'(rs3_q - 12'(mn3_q) * 12'(60));
  assign tm_ok = (s3_q.op <= OpDiv) && !s3_q.dz;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q    <= t_d;
      h1_q    <= hprod[31:27];
      qo1_q   <= quo_i;
      s1_q    <= side_i;
      rs2_q   <= rs_d;
      h2_q    <= h1_q;
      qo2_q   <= qo1_q;
      s2_q    <= s1_q;
      mn3_q   <= mprod[23:18];
      rs3_q   <= rs2_q;
      h3_q    <= h2_q;
      qo3_q   <= qo2_q;
      s3_q    <= s2_q;
      rh_q    <= tm_ok ? h3_q : '0;
      rm_q    <= tm_ok ? mn3_q : '0;
      rsec_q  <= tm_ok ? sec_d : '0;
      ratio_q <= ((s3_q.op == OpRatio) && !s3_q.dz) ? qo3_q : '0;
      lt_q    <= (s3_q.op == OpCmp) && s3_q.lt;
      eq_q    <= (s3_q.op == OpCmp) && s3_q.eq;
      gt_q    <= (s3_q.op == OpCmp) && s3_q.gt;
      dz_q    <= s3_q.dz;
    end
  end

  assign valid_o      = vo_q;
  assign r_hours_o    = rh_q;
  assign r_minutes_o  = rm_q;
  assign r_seconds_o  = rsec_q;
  assign ratio_o      = ratio_q;
  assign is_less_o    = lt_q;
  assign is_equal_o   = eq_q;
  assign is_greater_o = gt_q;
  assign div_zero_o   = dz_q;

endmodule

### tb/tod_checker.sv
// Checker for the time-of-day arithmetic unit: watches both channels, predicts results.
// Depends on tod_pkg for the opcode enum.
`timescale 1ns / 1ps

module tod_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  opcode_i,
  input  logic [4:0]  a_hours_i,
  input  logic [5:0]  a_minutes_i,
  input  logic [5:0]  a_seconds_i,
  input  logic [4:0]  b_hours_i,
  input  logic [5:0]  b_minutes_i,
  input  logic [5:0]  b_seconds_i,
  input  logic [15:0] scalar_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [4:0]  r_hours_i,
  input  logic [5:0]  r_minutes_i,
  input  logic [5:0]  r_seconds_i,
  input  logic [16:0] ratio_i,
  input  logic        is_less_i,
  input  logic        is_equal_i,
  input  logic        is_greater_i,
  input  logic        div_zero_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o
);
  import tod_pkg::*;

  typedef struct packed {
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [16:0] ratio;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        dz;
  } tod_result_t;

  tod_result_t expected_q[$];
  int          fail_count;
  int          results_seen;

  assign fail_count_o   = fail_count;
  assign pending_o      = expected_q.size();
  assign results_seen_o = results_seen;

  // fold a time to seconds of the day
  function automatic logic [16:0] day_secs(logic [4:0] h, logic [5:0] m, logic [5:0] s);
    int unsigned t;
    t = h * 3600 + m * 60 + s;
    return 17'(t % 86400);
  endfunction

  function automatic tod_result_t tod_compute(op_e op, logic [16:0] ta, logic [16:0] tb,
                                              logic [15:0] sc);
    tod_result_t r;
    int unsigned t;
    longint unsigned prod;
    r = '0;
    t = 0;
    case (op)
      OpAdd: t = (ta + tb) % 86400;
      OpSub: t = (ta + 86400 - tb) % 86400;
      OpInc: t = (ta + 1) % 86400;
      OpDec: t = (ta + 86400 - 1) % 86400;
      OpMul: begin
        prod = longint'(ta) * longint'(sc);
        t = int'(prod % 86400);
      end
      OpDiv: begin
        if (sc == 0) r.dz = 1'b1;
        else t = ta / sc;
      end
      OpRatio: begin
        if (tb == 0) r.dz = 1'b1;
        else r.ratio = ta / tb;
      end
      default: begin
        r.lt = ta < tb;
        r.eq = ta == tb;
        r.gt = ta > tb;
      end
    endcase
    if (op inside {OpAdd, OpSub, OpInc, OpDec, OpMul, OpDiv}) begin
      r.hours   = 5'(t / 3600);
      r.minutes = 6'((t / 60) % 60);
      r.seconds = 6'(t % 60);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // predict on input words, compare on output words
  always @(posedge clk_i or negedge rst_ni) begin
    tod_result_t want;
    if (!rst_ni) begin
      fail_count = 0;
      results_seen <= 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && in_ready_i)
        expected_q.push_back(tod_compute(op_e'(opcode_i),
            day_secs(a_hours_i, a_minutes_i, a_seconds_i),
            day_secs(b_hours_i, b_minutes_i, b_seconds_i), scalar_i));
      if (out_valid_i && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          report_mismatch("result words with nothing expected", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (r_hours_i != want.hours) report_mismatch("r_hours", r_hours_i, want.hours);
          if (r_minutes_i != want.minutes)
            report_mismatch("r_minutes", r_minutes_i, want.minutes);
          if (r_seconds_i != want.seconds)
            report_mismatch("r_seconds", r_seconds_i, want.seconds);
          if (ratio_i != want.ratio) report_mismatch("ratio", ratio_i, want.ratio);
          if (is_less_i != want.lt) report_mismatch("is_less", is_less_i, want.lt);
          if (is_equal_i != want.eq) report_mismatch("is_equal", is_equal_i, want.eq);
          if (is_greater_i != want.gt) report_mismatch("is_greater", is_greater_i, want.gt);
          if (div_zero_i != want.dz) report_mismatch("div_zero", div_zero_i, want.dz);
        end
      end
    end
  end

endmodule

### tb/tb_time_of_day_alu.sv
// Testbench top for time_of_day_alu: drives input words, throttles the output side.
// Depends on tod_pkg, time_of_day_alu and tod_checker.
`timescale 1ns / 1ps

module tb_time_of_day_alu;
  import tod_pkg::*;

  localparam int Latency    = 15;
  localparam int NumRandom  = 1030;
  localparam int StallLimit = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode = '0;
  logic [4:0]  a_h = '0, b_h = '0;
  logic [5:0]  a_m = '0, a_s = '0, b_m = '0, b_s = '0;
  logic [15:0] scalar = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  r_h;
  logic [5:0]  r_m, r_s;
  logic [16:0] ratio;
  logic        lt, eq, gt, dz;
  int          fail_count, pending, results_seen;
  int          idle_cycles = 0;
  int          words_sent = 0;
  int          rx_gap = 0;
  bit          hold_off = 1'b0;

  always #1 clk = ~clk;

  time_of_day_alu DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .opcode_i(opcode),
    .a_hours_i(a_h), .a_minutes_i(a_m), .a_seconds_i(a_s),
    .b_hours_i(b_h), .b_minutes_i(b_m), .b_seconds_i(b_s), .scalar_i(scalar),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .r_hours_o(r_h), .r_minutes_o(r_m), .r_seconds_o(r_s), .ratio_o(ratio),
    .is_less_o(lt), .is_equal_o(eq), .is_greater_o(gt), .div_zero_o(dz)
  );

  tod_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .opcode_i(opcode),
    .a_hours_i(a_h), .a_minutes_i(a_m), .a_seconds_i(a_s),
    .b_hours_i(b_h), .b_minutes_i(b_m), .b_seconds_i(b_s), .scalar_i(scalar),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .r_hours_i(r_h), .r_minutes_i(r_m), .r_seconds_i(r_s), .ratio_i(ratio),
    .is_less_i(lt), .is_equal_i(eq), .is_greater_i(gt), .div_zero_i(dz),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one word and hold it until accepted
  task automatic send_word(op_e op, logic [4:0] ah, logic [5:0] am, logic [5:0] as_,
                           logic [4:0] bh, logic [5:0] bm, logic [5:0] bs,
                           logic [15:0] sc);
    in_valid <= 1'b1;
    opcode   <= op;
    a_h <= ah; a_m <= am; a_s <= as_;
    b_h <= bh; b_m <= bm; b_s <= bs;
    scalar   <= sc;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // random word: mostly legal times, some raw out-of-range fields
  task automatic send_random();
    logic [4:0] ah, bh;
    logic [5:0] am, as_, bm, bs;
    logic [15:0] sc;
    if ($urandom_range(0, 9) < 8) begin
      ah = 5'($urandom_range(0, 23));
      am = 6'($urandom_range(0, 59));
      as_ = 6'($urandom_range(0, 59));
      bh = 5'($urandom_range(0, 23));
      bm = 6'($urandom_range(0, 59));
      bs = 6'($urandom_range(0, 59));
    end else begin
      ah = 5'($urandom); am = 6'($urandom); as_ = 6'($urandom);
      bh = 5'($urandom); bm = 6'($urandom); bs = 6'($urandom);
    end
    case ($urandom_range(0, 7))
      0: sc = '0;
      1: sc = 16'($urandom_range(1, 4));
      2: sc = 16'hffff;
      default: sc = 16'($urandom);
    endcase
    if ($urandom_range(0, 15) == 0) begin
      bh = '0; bm = '0; bs = '0;
    end else if ($urandom_range(0, 15) == 0) begin
      bh = ah; bm = am; bs = as_;
    end
    send_word(op_e'($urandom_range(0, 7)), ah, am, as_, bh, bm, bs, sc);
  endtask

  // receiver: random stalls of random length, one long hold-off on request
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap    <= rx_gap - 1;
    end else if ($urandom_range(0, 99) < 10) begin
      out_ready <= 1'b0;
      rx_gap    <= gap_len();
    end else out_ready <= 1'b1;
  end

  initial begin
    repeat (200) begin
      @(posedge clk);
      if (words_sent == 300) break;
    end
    wait (words_sent >= 300);
    hold_off = 1'b1;
    repeat (120) @(posedge clk);
    hold_off = 1'b0;
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !in_valid && pending == 0)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("timeout: no progress");
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every opcode, zero divisors, wrap-around
    send_word(OpAdd, 23, 59, 59, 0, 0, 1, 0);
    send_word(OpAdd, 23, 59, 59, 23, 59, 59, 0);
    send_word(OpSub, 0, 0, 0, 0, 0, 1, 0);
    send_word(OpSub, 12, 30, 0, 12, 30, 0, 0);
    send_word(OpInc, 23, 59, 59, 0, 0, 0, 0);
    send_word(OpDec, 0, 0, 0, 0, 0, 0, 0);
    send_word(OpMul, 23, 59, 59, 0, 0, 0, 16'hffff);
    send_word(OpMul, 1, 0, 0, 0, 0, 0, 0);
    send_word(OpDiv, 23, 59, 59, 0, 0, 0, 0);
    send_word(OpDiv, 23, 59, 59, 0, 0, 0, 1);
    send_word(OpDiv, 23, 59, 59, 0, 0, 0, 16'hffff);
    send_word(OpRatio, 23, 59, 59, 0, 0, 0, 0);
    send_word(OpRatio, 23, 59, 59, 0, 0, 1, 0);
    send_word(OpRatio, 0, 0, 1, 23, 59, 59, 0);
    send_word(OpRatio, 5, 0, 0, 24, 0, 0, 0);
    send_word(OpCmp, 1, 0, 0, 1, 0, 0, 0);
    send_word(OpCmp, 0, 0, 0, 23, 59, 59, 0);
    send_word(OpCmp, 23, 59, 59, 0, 0, 0, 0);
    send_word(OpAdd, 5'h1f, 6'h3f, 6'h3f, 5'h1f, 6'h3f, 6'h3f, 16'h5555);
    send_word(OpCmp, 24, 0, 0, 0, 0, 0, 16'haaaa);
    send_word(OpSub, 5'h1f, 6'h3f, 6'h3f, 0, 0, 0, 0);

    for (int i = 0; i < NumRandom; i++) begin
      send_random();
      // drain fully once, well clear of the hold-off
      if (i == 700) begin
        in_valid <= 1'b0;
        wait (pending == 0);
        @(posedge clk);
      end else if (!hold_off) idle_for(gap_len());
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (Latency + 5) @(posedge clk);
    $display("covered %0d words in, %0d results out, all opcodes with zero divisors",
             words_sent, results_seen);
    $display("and out-of-range fields, under random stalls and one long output hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tod_pkg.sv
hw/rtl/tod_front.sv
hw/rtl/tod_div.sv
hw/rtl/tod_split.sv
hw/rtl/time_of_day_alu.sv
tb/tod_checker.sv
tb/tb_time_of_day_alu.sv
